@@ rtl/vbls_pkg.sv @@
// ----------------------------------------------------------------------------
// vbls_pkg
// Shared types, codes and defaults of the blanking-line byte slicer.
// ----------------------------------------------------------------------------
package vbls_pkg;

	// Field widths
	localparam int PIX_W      = 8;
	localparam int THR_W      = 9;
	localparam int LIMIT_W    = 10;
	localparam int NBYTE_W    = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int SKIP_W     = 4;
	localparam int BIT_W      = 3;

	// Defaults
	localparam int PIXEL_BITS_DEF = 8;
	localparam int QUEUE_DEPTH    = 4;

	// Register reset values
	localparam logic [THR_W-1:0]   THR_RST   = 9'h070;
	localparam logic [PIX_W-1:0]   BLACK_RST = 8'h20;
	localparam logic [PIX_W-1:0]   WHITE_RST = 8'h30;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 10'd200;
	localparam logic [NBYTE_W-1:0] NBYTE_RST = 4'd11;

	// Framing distances
	localparam logic [SKIP_W-1:0] SKIP_LINE  = 4'd9;
	localparam logic [SKIP_W-1:0] SKIP_MARK  = 4'd12;
	localparam logic [SKIP_W-1:0] SKIP_FIRST = 4'd6;
	localparam logic [SKIP_W-1:0] SKIP_BIT   = 4'd4;
	localparam logic [SKIP_W-1:0] SKIP_TAIL  = 4'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_THRESHOLD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLACK_LEVEL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WHITE_LEVEL    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LIMIT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_LINE = 3'd4;

	typedef enum logic [1:0] {
		ST_DATA      = 2'd0,
		ST_LINE_DONE = 2'd1,
		ST_MARK_TO   = 2'd2,
		ST_SYNC_TO   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SKIP_MARK,
		PH_SEARCH_MARK,
		PH_SKIP_SYNC,
		PH_SEARCH_SYNC,
		PH_BIT_WAIT,
		PH_BIT_FIRST,
		PH_BIT_SECOND
	} phase_t;

	typedef struct packed {
		status_t             status;
		logic [7:0]          byte_value;
		logic [NBYTE_W-1:0]  byte_index;
		logic                last;
	} res_t;

endpackage

@@ rtl/vbls_front.sv @@
// ----------------------------------------------------------------------------
// vbls_front
// Line framing and bit slicing: one pixel per accepted transaction, at most
// one result per pixel. Also holds the configuration registers.
// ----------------------------------------------------------------------------
module vbls_front
	import vbls_pkg::*;
#(
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_accept,
	input  logic [PIX_W-1:0]      pixel,
	input  logic                  line_start,
	output logic                  res_valid,
	output res_t                  res
);

	localparam int PB = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;

	logic [THR_W-1:0]   thr_q;
	logic [PIX_W-1:0]   black_q;
	logic [PIX_W-1:0]   white_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [NBYTE_W-1:0] nbyte_q;

	phase_t             phase_q, phase_d;
	logic [SKIP_W-1:0]  skip_q, skip_d;
	logic [LIMIT_W-1:0] search_q, search_d;
	logic [BIT_W-1:0]   bit_q, bit_d;
	logic [NBYTE_W-1:0] byte_q, byte_d;
	logic [7:0]         shift_q, shift_d;
	logic [PIX_W-1:0]   first_q, first_d;

	logic [PIX_W-1:0]   pix;
	logic [LIMIT_W-1:0] search_inc;
	logic               timeout;
	logic               mark_hit;
	logic               sync_hit;
	logic               bit_one;
	logic [THR_W-1:0]   pair_sum;
	logic [7:0]         shift_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THR_RST;
			black_q <= BLACK_RST;
			white_q <= WHITE_RST;
			limit_q <= LIMIT_RST;
			nbyte_q <= NBYTE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BIT_THRESHOLD:  thr_q   <= cfg_data[THR_W-1:0];
				CFG_BLACK_LEVEL:    black_q <= cfg_data[PIX_W-1:0];
				CFG_WHITE_LEVEL:    white_q <= cfg_data[PIX_W-1:0];
				CFG_SEARCH_LIMIT:   limit_q <= cfg_data[LIMIT_W-1:0];
				CFG_BYTES_PER_LINE: nbyte_q <= cfg_data[NBYTE_W-1:0];
				default: ;
			endcase
		end
	end

	assign pix        = PIX_W'(pixel[PB-1:0]);
	assign search_inc = search_q + LIMIT_W'(1);
	assign timeout    = (search_inc >= limit_q);
	assign mark_hit   = (pix <= white_q);
	assign sync_hit   = (pix >= black_q);
	assign pair_sum   = THR_W'(first_q) + THR_W'(pix);
	assign bit_one    = (pair_sum > thr_q);
	assign shift_new  = shift_q | (bit_one ? (8'd1 << bit_q) : 8'd0);

	// Next state
	always_comb begin
		phase_d  = phase_q;
		skip_d   = skip_q;
		search_d = search_q;
		bit_d    = bit_q;
		byte_d   = byte_q;
		shift_d  = shift_q;
		first_d  = first_q;
		if (line_start) begin
			phase_d  = PH_SKIP_MARK;
			skip_d   = SKIP_LINE;
			search_d = '0;
			bit_d    = '0;
			byte_d   = '0;
			shift_d  = '0;
			first_d  = '0;
		end else begin
			unique case (phase_q)
				PH_SKIP_MARK, PH_SKIP_SYNC, PH_BIT_WAIT: begin
					if (skip_q <= SKIP_W'(1)) begin
						skip_d   = '0;
						search_d = '0;
						unique case (phase_q)
							PH_SKIP_MARK: phase_d = PH_SEARCH_MARK;
							PH_SKIP_SYNC: phase_d = PH_SEARCH_SYNC;
							default:      phase_d = PH_BIT_FIRST;
						endcase
					end else begin
						skip_d = skip_q - SKIP_W'(1);
					end
				end
				PH_SEARCH_MARK: begin
					search_d = search_inc;
					if (timeout) begin
						phase_d = PH_IDLE;
					end else if (mark_hit) begin
						skip_d  = SKIP_MARK;
						phase_d = PH_SKIP_SYNC;
					end
				end
				PH_SEARCH_SYNC: begin
					search_d = search_inc;
					if (timeout) begin
						phase_d = PH_IDLE;
					end else if (sync_hit) begin
						if (byte_q >= nbyte_q) begin
							phase_d = PH_IDLE;
						end else begin
							skip_d  = SKIP_FIRST;
							bit_d   = '0;
							shift_d = '0;
							phase_d = PH_BIT_WAIT;
						end
					end
				end
				PH_BIT_FIRST: begin
					first_d = pix;
					phase_d = PH_BIT_SECOND;
				end
				PH_BIT_SECOND: begin
					shift_d = shift_new;
					if (bit_q == BIT_W'(7)) begin
						byte_d  = byte_q + NBYTE_W'(1);
						bit_d   = '0;
						skip_d  = SKIP_TAIL;
						phase_d = PH_SKIP_SYNC;
					end else begin
						bit_d   = bit_q + BIT_W'(1);
						skip_d  = SKIP_BIT;
						phase_d = PH_BIT_WAIT;
					end
				end
				default: ;
			endcase
		end
	end

	// Result
	always_comb begin
		res_valid      = 1'b0;
		res.status     = ST_DATA;
		res.byte_value = '0;
		res.byte_index = '0;
		res.last       = 1'b0;
		if (in_accept && !line_start) begin
			unique case (phase_q)
				PH_SEARCH_MARK: begin
					if (timeout) begin
						res_valid  = 1'b1;
						res.status = ST_MARK_TO;
						res.last   = 1'b1;
					end
				end
				PH_SEARCH_SYNC: begin
					if (timeout) begin
						res_valid  = 1'b1;
						res.status = ST_SYNC_TO;
						res.last   = 1'b1;
					end else if (sync_hit && byte_q >= nbyte_q) begin
						res_valid  = 1'b1;
						res.status = ST_LINE_DONE;
						res.last   = 1'b1;
					end
				end
				PH_BIT_SECOND: begin
					if (bit_q == BIT_W'(7)) begin
						res_valid      = 1'b1;
						res.byte_value = shift_new;
						res.byte_index = byte_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			skip_q   <= '0;
			search_q <= '0;
			bit_q    <= '0;
			byte_q   <= '0;
			shift_q  <= '0;
			first_q  <= '0;
		end else if (in_accept) begin
			phase_q  <= phase_d;
			skip_q   <= skip_d;
			search_q <= search_d;
			bit_q    <= bit_d;
			byte_q   <= byte_d;
			shift_q  <= shift_d;
			first_q  <= first_d;
		end
	end

endmodule

@@ rtl/vbls_queue.sv @@
// ----------------------------------------------------------------------------
// vbls_queue
// Short result queue between the slicer and the output stage.
// ----------------------------------------------------------------------------
module vbls_queue
	import vbls_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output res_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	res_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full      = (cnt_q == CNT_FULL);
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("result pushed into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop)
		else $error("pop from empty queue");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop && !full) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("queue count lost a push");
`endif

endmodule

@@ rtl/vbls_back.sv @@
// ----------------------------------------------------------------------------
// vbls_back
// Output register: pulls results from the queue and holds them until taken.
// ----------------------------------------------------------------------------
module vbls_back
	import vbls_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic q_not_empty,
	input  res_t q_head,
	output logic q_pop,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	logic valid_q;
	res_t res_q;

	// Refill when empty or when the held result leaves this cycle
	assign q_pop     = q_not_empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= q_not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= q_head;
		end
	end

endmodule

@@ rtl/vbli_line_byte_slicer_top.sv @@
// ----------------------------------------------------------------------------
// vbi_line_byte_slicer_top
// Slices the data bytes out of one blanking line of pixel samples.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one pixel per transaction on s_axis; tuser marks the first pixel of
//   a line and restarts framing. Results leave on m_axis: a status code, the
//   byte value and its index in tdata, tlast set on the final result of a
//   line (line complete or a search timeout). Pixels outside a line give no
//   result.
//   Throughput: one pixel per cycle while s_axis_tready is high, set by the
//   framing state machine in the front end. A result caused by an accepted
//   pixel passes the result queue and the output register to reach m_axis.
//   A four-entry result queue and an output register decouple the two sides;
//   s_axis_tready drops only when the queue is full, i.e. after the receiver
//   has stalled for several results.
//   Reset clears framing state, the queue and the output stage and loads the
//   register defaults. Write registers through cfg_we/cfg_index/cfg_data
//   while no line is in progress.
// ----------------------------------------------------------------------------
module vbi_line_byte_slicer_top
	import vbls_pkg::*;
#(
	parameter int PIXEL_BITS  = PIXEL_BITS_DEF,
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // [7:0] pixel
	input  logic                  s_axis_tuser,  // [0] line_start
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [15:0]           m_axis_tdata,  // [1:0] status, [9:2] byte_value,
	                                             // [13:10] byte_index, [15:14] zero
	output logic                  m_axis_tlast   // last
);

	logic in_accept;
	logic res_valid;
	res_t res;
	logic q_full, q_not_empty, q_pop;
	res_t q_head;
	res_t out_res;

	assign s_axis_tready = !q_full;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	vbls_front #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_accept (in_accept),
		.pixel     (s_axis_tdata),
		.line_start(s_axis_tuser),
		.res_valid (res_valid),
		.res       (res)
	);

	vbls_queue #(
		.DEPTH(QUEUE_DEPTH_P)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_data(res),
		.pop      (q_pop),
		.full     (q_full),
		.not_empty(q_not_empty),
		.head     (q_head)
	);

	vbls_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_not_empty(q_not_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (out_res)
	);

	assign m_axis_tdata = {2'b00, out_res.byte_index, out_res.byte_value, out_res.status};
	assign m_axis_tlast = out_res.last;

endmodule
